FILE: hdl/bal_pkg.sv
// ============================================================================
// bal_pkg
// Shared types, codes and constants of the bounded array list.
// ============================================================================
package bal_pkg;

    // Default build parameters
    localparam int DEPTH_DEF      = 64;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed field widths of the request and result words
    localparam int KIND_W   = 2;
    localparam int POS_W    = 6;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // Configuration register file
    localparam int                 CAP_W      = 7;
    localparam logic [CAP_W-1:0]   CAP_RESET  = 7'd64;
    localparam int                 APB_ADDR_W = 3;
    localparam int                 APB_DATA_W = 32;
    localparam logic               REG_CAPACITY = 1'b0;   // register index bit paddr[2]

    // Request kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_GET    = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_INSERT = 2'd2,
        KIND_REMOVE = 2'd3
    } t_kind;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_INDEX = 2'd2
    } t_status;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_RD_CAP,
        S_RM_CHK,
        S_RM_RD,
        S_RM_WR,
        S_SH_RD,
        S_SH_WR,
        S_PUT,
        S_FINISH
    } t_state;

    // Memory address source
    typedef enum logic [2:0] {
        ADDR_POS,
        ADDR_COUNT,
        ADDR_IDX,
        ADDR_IDX_M1,
        ADDR_IDX_P1
    } t_addr_sel;

    // Controller to datapath commands
    typedef struct packed {
        logic      load_in;
        logic      set_stat;
        t_status   stat_code;
        logic      mem_rd;
        logic      mem_wr;
        t_addr_sel addr_sel;
        logic      wr_value;     // 1: request value, 0: read-back word
        logic      cap_rd;
        logic      idx_ld_count;
        logic      idx_ld_pos;
        logic      idx_dec;
        logic      idx_inc;
        logic      cnt_inc;
        logic      cnt_dec;
        logic      out_load;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        t_kind kind;
        logic  full;
        logic  in_range;
        logic  last_shift;
        logic  rm_more;
        logic  out_busy;
    } t_dp_stat;

endpackage

FILE: hdl/bal_req_if.sv
// ============================================================================
// bal_req_if
// Request channel: valid/ready handshake with the request word.
// ============================================================================
interface bal_req_if import bal_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [POS_W-1:0]    position;
    logic [VALUE_W-1:0]  entry_value;

    modport source (output valid, kind, position, entry_value, input ready);
    modport sink   (input valid, kind, position, entry_value, output ready);

endinterface

FILE: hdl/bal_rsp_if.sv
// ============================================================================
// bal_rsp_if
// Result channel: valid/ready handshake with the result word.
// ============================================================================
interface bal_rsp_if import bal_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  read_value;
    logic [COUNT_W-1:0]  entry_count;

    modport source (output valid, status, read_value, entry_count, input ready);
    modport sink   (input valid, status, read_value, entry_count, output ready);

endinterface

FILE: hdl/bal_ctrl.sv
// ============================================================================
// bal_ctrl
// Sequencer of the list: decides each request and steps the entry shifts.
// ============================================================================
module bal_ctrl import bal_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                unique case (i_stat.kind)
                    KIND_GET:    n_state = i_stat.in_range ? S_RD_CAP : S_FINISH;
                    KIND_APPEND: n_state = S_FINISH;
                    KIND_INSERT: n_state = (!i_stat.full && i_stat.in_range) ? S_SH_RD
                                                                             : S_FINISH;
                    KIND_REMOVE: n_state = i_stat.in_range ? S_RD_CAP : S_FINISH;
                    default:     n_state = S_FINISH;
                endcase
            end
            S_RD_CAP: n_state = (i_stat.kind == KIND_REMOVE) ? S_RM_CHK : S_FINISH;
            S_RM_CHK: n_state = i_stat.rm_more ? S_RM_RD : S_FINISH;
            S_RM_RD:  n_state = S_RM_WR;
            S_RM_WR:  n_state = S_RM_CHK;
            S_SH_RD:  n_state = S_SH_WR;
            S_SH_WR:  n_state = i_stat.last_shift ? S_PUT : S_SH_RD;
            S_PUT:    n_state = S_FINISH;
            S_FINISH: begin
                if (!i_stat.out_busy) n_state = S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // Command outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.stat_code = ST_DONE;
        o_cmd.addr_sel  = ADDR_POS;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            S_DECIDE: begin
                o_cmd.set_stat = 1'b1;
                unique case (i_stat.kind)
                    KIND_GET: begin
                        o_cmd.stat_code = i_stat.in_range ? ST_DONE : ST_INDEX;
                        o_cmd.mem_rd    = i_stat.in_range;
                        o_cmd.addr_sel  = ADDR_POS;
                    end
                    KIND_APPEND: begin
                        o_cmd.stat_code = i_stat.full ? ST_FULL : ST_DONE;
                        o_cmd.mem_wr    = !i_stat.full;
                        o_cmd.addr_sel  = ADDR_COUNT;
                        o_cmd.wr_value  = 1'b1;
                        o_cmd.cnt_inc   = !i_stat.full;
                    end
                    KIND_INSERT: begin
                        // full is reported ahead of a bad index
                        if (i_stat.full) begin
                            o_cmd.stat_code = ST_FULL;
                        end else if (!i_stat.in_range) begin
                            o_cmd.stat_code = ST_INDEX;
                        end else begin
                            o_cmd.stat_code    = ST_DONE;
                            o_cmd.idx_ld_count = 1'b1;
                        end
                    end
                    KIND_REMOVE: begin
                        o_cmd.stat_code = i_stat.in_range ? ST_DONE : ST_INDEX;
                        o_cmd.mem_rd    = i_stat.in_range;
                        o_cmd.addr_sel  = ADDR_POS;
                    end
                    default: ;
                endcase
            end
            S_RD_CAP: begin
                o_cmd.cap_rd     = 1'b1;
                o_cmd.idx_ld_pos = 1'b1;
            end
            S_RM_CHK: begin
                o_cmd.cnt_dec = !i_stat.rm_more;
            end
            S_RM_RD: begin
                o_cmd.mem_rd   = 1'b1;
                o_cmd.addr_sel = ADDR_IDX_P1;
            end
            S_RM_WR: begin
                o_cmd.mem_wr   = 1'b1;
                o_cmd.addr_sel = ADDR_IDX;
                o_cmd.idx_inc  = 1'b1;
            end
            S_SH_RD: begin
                o_cmd.mem_rd   = 1'b1;
                o_cmd.addr_sel = ADDR_IDX_M1;
            end
            S_SH_WR: begin
                o_cmd.mem_wr   = 1'b1;
                o_cmd.addr_sel = ADDR_IDX;
                o_cmd.idx_dec  = 1'b1;
            end
            S_PUT: begin
                o_cmd.mem_wr   = 1'b1;
                o_cmd.addr_sel = ADDR_POS;
                o_cmd.wr_value = 1'b1;
                o_cmd.cnt_inc  = 1'b1;
            end
            S_FINISH: begin
                o_cmd.out_load = !i_stat.out_busy;
            end
            default: ;
        endcase
    end

endmodule

FILE: hdl/bal_dpath.sv
// ============================================================================
// bal_dpath
// Entry memory, fill count, walk index, request latch and result register.
// ============================================================================
module bal_dpath import bal_pkg::*; #(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat,
    input  logic [CAP_W-1:0]    i_capacity,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [POS_W-1:0]    i_position,
    input  logic [VALUE_W-1:0]  i_entry_value,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic [VALUE_W-1:0]  o_read_value,
    output logic [COUNT_W-1:0]  o_entry_count
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    // Entry storage, single port, registered read
    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;

    // Request latch
    logic [KIND_W-1:0]     r_kind;
    logic [POS_W-1:0]      r_pos;
    logic [DATA_WIDTH-1:0] r_value;

    // List state and walk index
    logic [CNT_W-1:0]      r_count;
    logic [ADDR_W-1:0]     r_idx;

    // Result being built and result register
    logic [STATUS_W-1:0]   r_stat_code;
    logic [DATA_WIDTH-1:0] r_rd;
    logic                  r_out_valid;
    logic [STATUS_W-1:0]   r_out_status;
    logic [VALUE_W-1:0]    r_out_value;
    logic [COUNT_W-1:0]    r_out_count;

    logic [63:0]           w_in64;
    logic [63:0]           w_rd64;
    logic [ADDR_W-1:0]     w_pos_addr;
    logic [ADDR_W-1:0]     w_addr;
    logic [DATA_WIDTH-1:0] w_wdata;
    logic [CMP_W-1:0]      w_count_c;

    // Width adaption of the value fields
    assign w_in64     = 64'(i_entry_value);
    assign w_rd64     = 64'(r_rd);
    assign w_pos_addr = ADDR_W'(r_pos);
    assign w_count_c  = CMP_W'(r_count);

    // Address and write data selection
    always_comb begin
        case (i_cmd.addr_sel)
            ADDR_POS:    w_addr = w_pos_addr;
            ADDR_COUNT:  w_addr = ADDR_W'(r_count);
            ADDR_IDX:    w_addr = r_idx;
            ADDR_IDX_M1: w_addr = r_idx - ADDR_W'(1);
            ADDR_IDX_P1: w_addr = r_idx + ADDR_W'(1);
            default:     w_addr = r_idx;
        endcase
    end
    assign w_wdata = i_cmd.wr_value ? r_value : r_rdata;

    // Entry memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) r_mem[w_addr] <= w_wdata;
        if (i_cmd.mem_rd) r_rdata <= r_mem[w_addr];
    end

    // Request latch and result being built
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_kind  <= i_kind;
            r_pos   <= i_position;
            r_value <= w_in64[DATA_WIDTH-1:0];
            r_rd    <= '0;
        end else if (i_cmd.cap_rd) begin
            r_rd <= r_rdata;
        end
        if (i_cmd.set_stat) r_stat_code <= i_cmd.stat_code;
    end

    // Walk index
    always_ff @(posedge i_clk) begin
        if (i_cmd.idx_ld_count) begin
            r_idx <= ADDR_W'(r_count);
        end else if (i_cmd.idx_ld_pos) begin
            r_idx <= w_pos_addr;
        end else if (i_cmd.idx_dec) begin
            r_idx <= r_idx - ADDR_W'(1);
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + ADDR_W'(1);
        end
    end

    // Fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_count <= r_count + CNT_W'(1);
        end else if (i_cmd.cnt_dec) begin
            r_count <= r_count - CNT_W'(1);
        end
    end

    // Result register, held until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= r_stat_code;
            r_out_value  <= w_rd64[VALUE_W-1:0];
            r_out_count  <= COUNT_W'(r_count);
        end
    end

    // Status toward the controller
    assign o_stat.kind       = t_kind'(r_kind);
    assign o_stat.full       = (w_count_c >= CMP_W'(i_capacity)) ||
                               (r_count == CNT_W'(DEPTH));
    assign o_stat.in_range   = CMP_W'(r_pos) < w_count_c;
    assign o_stat.last_shift = (r_idx - ADDR_W'(1)) == w_pos_addr;
    assign o_stat.rm_more    = (CMP_W'(r_idx) + CMP_W'(1)) < w_count_c;
    assign o_stat.out_busy   = r_out_valid && !i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_read_value  = r_out_value;
    assign o_entry_count = r_out_count;

endmodule

FILE: hdl/bounded_array_list_top.sv
// ============================================================================
// bounded_array_list_top
// Bounded ordered list with get, append, insert-before and remove-at requests.
// ============================================================================
// One request is taken at a time; the next is taken once the previous result
// sits in the output register, which holds it until the sink takes it. The
// entries live in a single-port memory that does one read or one write per
// cycle; insert and remove move the entries between the position and the fill
// count through that port one at a time, a read and then a write for each.
// Entries above the fill count are never read, so the memory needs no
// clearing after reset. The capacity register sits at byte address 0 and
// resets to 64; the usable capacity is also capped by DEPTH.
module bounded_array_list_top import bal_pkg::*; #(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bal_req_if.sink               i_req,
    bal_rsp_if.source             o_rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [CAP_W-1:0] r_capacity;
    logic             w_in_ready;
    t_dp_cmd          w_cmd;
    t_dp_stat         w_stat;

    // Capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_CAPACITY)) begin
            r_capacity <= pwdata[CAP_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CAPACITY) ? APB_DATA_W'(r_capacity) : '0;

    // Sequencer
    bal_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    assign i_req.ready = w_in_ready;

    // Storage and result path
    bal_dpath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_capacity    (r_capacity),
        .i_kind        (i_req.kind),
        .i_position    (i_req.position),
        .i_entry_value (i_req.entry_value),
        .i_out_ready   (o_rsp.ready),
        .o_out_valid   (o_rsp.valid),
        .o_status      (o_rsp.status),
        .o_read_value  (o_rsp.read_value),
        .o_entry_count (o_rsp.entry_count)
    );

endmodule
